// File: hw/rtl/lbfps_pkg.sv
// Shared types and constants for the light bar filter and pair select block.
// No dependencies; used by every module under hw/rtl.
`timescale 1ns / 1ps
`default_nettype none

package lbfps_pkg;

	// Fixed field widths
	localparam int IDX_W     = 6;
	localparam int XY_W      = 16;
	localparam int AREA_W    = 28;
	localparam int ANG_W     = 13;
	localparam int DIST_W    = 33;
	localparam int COUNT_W   = 7;
	localparam int ENTRY_W   = 2 * XY_W + IDX_W;
	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 28;
	localparam int IN_W      = 112;
	localparam int OUT_W     = 56;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_MIN_AREA        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_ASPECT      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ASPECT      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_COMPACTNESS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_Y_OFFSET    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE    = 3'd7;

	// Thresholds used by the bar filter
	typedef struct packed {
		logic [27:0] min_area;
		logic [7:0]  min_aspect;
		logic [7:0]  max_aspect;
		logic [11:0] min_angle;
		logic [11:0] max_angle;
		logic [10:0] min_compactness;
	} filt_cfg_t;

	// Limits used by the pair search
	typedef struct packed {
		logic [15:0] max_y_offset;
		logic [15:0] max_distance;
	} pair_cfg_t;

	// Classified bar handed from the filter to the search engine
	typedef struct packed {
		logic             keep;
		logic             last;
		logic [IDX_W-1:0] idx;
		logic [XY_W-1:0]  cy;
		logic [XY_W-1:0]  cx;
	} bar_t;

	// One frame result
	typedef struct packed {
		logic               found;
		logic [IDX_W-1:0]   first_bar;
		logic [IDX_W-1:0]   second_bar;
		logic [DIST_W-1:0]  distance_squared;
		logic [COUNT_W-1:0] kept_count;
	} result_t;

endpackage

`default_nettype wire

// File: hw/rtl/light_bar_filter_pair_select_top.sv
// Top level of the light bar filter and pair select block: ports, configuration registers.
// Depends on lbfps_pkg, lbfps_front, lbfps_queue and lbfps_back.
//
// Bars enter on the s_ side, one per cycle while the filter pipeline and the four-entry
// queue have room; the search engine takes one queued bar per cycle while it is idle and
// stores the kept ones. The bar with tlast starts the pair search, which holds the queue
// while it runs: one memory read per pair through the distance pipeline, plus a row fetch
// and pipeline drain per kept bar but the last. Bars keep being accepted into the queue
// until it fills. One result leaves on the m_ side per frame. Configuration writes take
// effect at the next clock edge and are meant to be made only between frames. The bar
// memory needs no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module light_bar_filter_pair_select_top #(
	parameter int MAX_BARS = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// area, box_width, box_height, box_angle, center_x, center_y, zero pad
	input  wire logic [lbfps_pkg::IN_W-1:0]      s_tdata,
	input  wire logic                            s_tlast,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// first_bar, second_bar, distance_squared, kept_count, zero pad
	output logic [lbfps_pkg::OUT_W-1:0]          m_tdata,
	// pair_found
	output logic                                 m_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	input  wire logic                            cfg_we,
	input  wire logic [lbfps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lbfps_pkg::CFG_W-1:0]     cfg_data
);

	lbfps_pkg::filt_cfg_t filt_cfg_q;
	lbfps_pkg::pair_cfg_t pair_cfg_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_cfg_q.min_area        <= 28'd800;
			filt_cfg_q.min_aspect      <= 8'd24;
			filt_cfg_q.max_aspect      <= 8'd80;
			filt_cfg_q.min_angle       <= 12'd720;
			filt_cfg_q.max_angle       <= 12'd2160;
			filt_cfg_q.min_compactness <= 11'd307;
			pair_cfg_q.max_y_offset    <= 16'd1600;
			pair_cfg_q.max_distance    <= 16'd65535;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lbfps_pkg::REG_MIN_AREA:        filt_cfg_q.min_area <= cfg_data[27:0];
				lbfps_pkg::REG_MIN_ASPECT:      filt_cfg_q.min_aspect <= cfg_data[7:0];
				lbfps_pkg::REG_MAX_ASPECT:      filt_cfg_q.max_aspect <= cfg_data[7:0];
				lbfps_pkg::REG_MIN_ANGLE:       filt_cfg_q.min_angle <= cfg_data[11:0];
				lbfps_pkg::REG_MAX_ANGLE:       filt_cfg_q.max_angle <= cfg_data[11:0];
				lbfps_pkg::REG_MIN_COMPACTNESS: filt_cfg_q.min_compactness <= cfg_data[10:0];
				lbfps_pkg::REG_MAX_Y_OFFSET:    pair_cfg_q.max_y_offset <= cfg_data[15:0];
				lbfps_pkg::REG_MAX_DISTANCE:    pair_cfg_q.max_distance <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Filter front end
	logic            push_valid, push_ready;
	lbfps_pkg::bar_t push_bar;

	lbfps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (filt_cfg_q),
		.s_valid    (s_tvalid),
		.s_ready    (s_tready),
		.area       (s_tdata[27:0]),
		.box_width  (s_tdata[43:28]),
		.box_height (s_tdata[59:44]),
		.box_angle  (s_tdata[72:60]),
		.center_x   (s_tdata[88:73]),
		.center_y   (s_tdata[104:89]),
		.last_bar   (s_tlast),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_bar   (push_bar)
	);

	// Queue between filter and search
	logic            pop_valid, pop_ready;
	lbfps_pkg::bar_t pop_bar;

	lbfps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_bar    (push_bar),
		.out_valid (pop_valid),
		.out_ready (pop_ready),
		.out_bar   (pop_bar)
	);

	// Store and pair search
	lbfps_pkg::result_t res;

	lbfps_back #(
		.MAX_BARS (MAX_BARS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (pair_cfg_q),
		.bar_valid (pop_valid),
		.bar_ready (pop_ready),
		.bar       (pop_bar),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// Output packing
	assign m_tuser = res.found;
	assign m_tdata = {4'd0, res.kept_count, res.distance_squared, res.second_bar, res.first_bar};

	// No pair means the index and distance fields are zero
	a_no_pair_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata[44:0] == 45'd0))
		else $error("result without a pair carries nonzero pair fields");

	// A found pair is always closer than the distance cap
	a_pair_below_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |->
			(m_tdata[44:12] < (33'(pair_cfg_q.max_distance) * 33'(pair_cfg_q.max_distance))))
		else $error("chosen pair is not below the distance cap");

	// The kept count never passes the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(m_tdata[51:45]) <= 32'(MAX_BARS)))
		else $error("kept count exceeds the store depth");

endmodule

`default_nettype wire

// File: hw/rtl/lbfps_front.sv
// Bar filter: two-stage pipeline running the area, aspect, angle and compactness tests.
// Depends on lbfps_pkg. Feeds classified bars to lbfps_queue.
`timescale 1ns / 1ps
`default_nettype none

module lbfps_front (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire lbfps_pkg::filt_cfg_t    cfg,
	input  wire logic                    s_valid,
	output logic                         s_ready,
	input  wire logic [lbfps_pkg::AREA_W-1:0] area,
	input  wire logic [lbfps_pkg::XY_W-1:0]   box_width,
	input  wire logic [lbfps_pkg::XY_W-1:0]   box_height,
	input  wire logic [lbfps_pkg::ANG_W-1:0]  box_angle,
	input  wire logic [lbfps_pkg::XY_W-1:0]   center_x,
	input  wire logic [lbfps_pkg::XY_W-1:0]   center_y,
	input  wire logic                    last_bar,
	output logic                         push_valid,
	input  wire logic                    push_ready,
	output lbfps_pkg::bar_t              push_bar
);

	// Stall control: stage 2 drains into the queue
	logic v_s1, v_s2, adv1, adv2, acc;
	assign adv2       = !v_s2 || push_ready;
	assign adv1       = !v_s1 || adv2;
	assign s_ready    = adv1;
	assign acc        = s_valid && s_ready;
	assign push_valid = v_s2;

	// Input order index, restarts after the frame's last bar
	logic [lbfps_pkg::IDX_W-1:0] idx_q;

	// Stage 1 combinational terms
	logic [15:0] lng, sht;
	logic [12:0] mag;
	logic        basic_ok;
	assign lng = (box_width > box_height) ? box_width : box_height;
	assign sht = (box_width > box_height) ? box_height : box_width;
	assign mag = box_angle[12] ? (13'h0000 - box_angle) : box_angle;
	assign basic_ok = (area >= cfg.min_area) && (sht != 16'd0) &&
		(mag >= {1'b0, cfg.min_angle}) && (mag <= {1'b0, cfg.max_angle});

	// Stage 1 registers
	logic                        ok_s1;
	logic [15:0]                 lng_s1;
	logic [23:0]                 plo_s1, phi_s1;
	logic [31:0]                 wh_s1;
	logic [27:0]                 area_s1;
	logic [15:0]                 cx_s1, cy_s1;
	logic [lbfps_pkg::IDX_W-1:0] idx_s1;
	logic                        last_s1;

	// Stage 2 registers
	logic                        ok_s2;
	logic [42:0]                 cprod_s2;
	logic [27:0]                 area_s2;
	logic [15:0]                 cx_s2, cy_s2;
	logic [lbfps_pkg::IDX_W-1:0] idx_s2;
	logic                        last_s2;

	// Aspect verdict from stage 1 products
	logic [23:0] lng16;
	logic        aspect_ok;
	assign lng16     = {4'd0, lng_s1, 4'd0};
	assign aspect_ok = !(lng16 < plo_s1) && !(lng16 > phi_s1);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			idx_q <= '0;
		end else begin
			if (adv1) v_s1 <= s_valid;
			if (adv2) v_s2 <= v_s1;
			if (acc) idx_q <= last_bar ? '0 : idx_q + 1'b1;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (adv1) begin
			ok_s1   <= basic_ok;
			lng_s1  <= lng;
			plo_s1  <= cfg.min_aspect * sht;
			phi_s1  <= cfg.max_aspect * sht;
			wh_s1   <= box_width * box_height;
			area_s1 <= area;
			cx_s1   <= center_x;
			cy_s1   <= center_y;
			idx_s1  <= idx_q;
			last_s1 <= last_bar;
		end
		if (adv2) begin
			ok_s2    <= ok_s1 && aspect_ok;
			cprod_s2 <= cfg.min_compactness * wh_s1;
			area_s2  <= area_s1;
			cx_s2    <= cx_s1;
			cy_s2    <= cy_s1;
			idx_s2   <= idx_s1;
			last_s2  <= last_s1;
		end
	end

	// Compactness: 16384*area against min_compactness*w*h
	assign push_bar.keep = ok_s2 && ({1'b0, area_s2, 14'd0} >= cprod_s2);
	assign push_bar.last = last_s2;
	assign push_bar.idx  = idx_s2;
	assign push_bar.cy   = cy_s2;
	assign push_bar.cx   = cx_s2;

endmodule

`default_nettype wire

// File: hw/rtl/lbfps_queue.sv
// Short FIFO of classified bars between the filter and the search engine.
// Depends on lbfps_pkg (bar_t, depth constants).
`timescale 1ns / 1ps
`default_nettype none

module lbfps_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire lbfps_pkg::bar_t in_bar,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output lbfps_pkg::bar_t      out_bar
);

	lbfps_pkg::bar_t slot_q [lbfps_pkg::Q_DEPTH];
	logic [lbfps_pkg::Q_PTR_W-1:0] wr_q, rd_q;
	logic [lbfps_pkg::Q_PTR_W:0]   cnt_q;
	logic push, pop;

	assign in_ready  = (cnt_q != 3'(lbfps_pkg::Q_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_bar   = slot_q[rd_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= in_bar;
	end

endmodule

`default_nettype wire

// File: hw/rtl/lbfps_back.sv
// Search engine: stores kept centers and runs the closest-pair search on the last bar.
// Depends on lbfps_pkg. Holds the bar memory and the result register.
`timescale 1ns / 1ps
`default_nettype none

module lbfps_back #(
	parameter int MAX_BARS = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lbfps_pkg::pair_cfg_t cfg,
	input  wire logic                 bar_valid,
	output logic                      bar_ready,
	input  wire lbfps_pkg::bar_t      bar,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output lbfps_pkg::result_t        res
);

	localparam int AW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
	localparam int CW = $clog2(MAX_BARS + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RDI   = 3'd1;
	localparam logic [2:0] ST_LATI  = 3'd2;
	localparam logic [2:0] ST_RUNJ  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]    state_q;
	logic [CW-1:0] total_q, i_q, j_q;

	// Bar memory: {idx, cy, cx}
	logic [lbfps_pkg::ENTRY_W-1:0] mem [MAX_BARS];
	logic [lbfps_pkg::ENTRY_W-1:0] rdata_q;
	logic [AW-1:0]                 raddr;
	logic                          pop, store;

	assign bar_ready = (state_q == ST_IDLE);
	assign pop       = bar_valid && bar_ready;
	assign store     = pop && bar.keep && (total_q < CW'(MAX_BARS));
	assign raddr     = (state_q == ST_RDI) ? i_q[AW-1:0] : j_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (store) mem[total_q[AW-1:0]] <= {bar.idx, bar.cy, bar.cx};
		rdata_q <= mem[raddr];
	end

	// Loop bounds
	logic more_i, last_j, issue, drained;
	assign more_i  = ((CW + 1)'(i_q) + 1'b1) < (CW + 1)'(total_q);
	assign last_j  = ((CW + 1)'(j_q) + 1'b1) == (CW + 1)'(total_q);
	assign issue   = (state_q == ST_RUNJ);

	// Distance pipeline registers
	logic [15:0]                 xi_q, yi_q;
	logic [lbfps_pkg::IDX_W-1:0] idxi_q;
	logic                        v_s1, v_s2, v_s3;
	logic                        ok_s2, ok_s3;
	logic [15:0]                 dx_s2, dy_s2;
	logic [31:0]                 sqx_s3, sqy_s3;
	logic [lbfps_pkg::IDX_W-1:0] idxj_s2, idxj_s3;
	assign drained = !v_s1 && !v_s2 && !v_s3;

	// Stage 1 terms from the memory read
	logic [15:0] xj, yj, dx, dy;
	assign xj = rdata_q[15:0];
	assign yj = rdata_q[31:16];
	assign dx = (xi_q > xj) ? xi_q - xj : xj - xi_q;
	assign dy = (yi_q > yj) ? yi_q - yj : yj - yi_q;

	// Compare against the best so far
	logic [lbfps_pkg::DIST_W-1:0] d2, best_q;
	logic                         better;
	logic                         found_q;
	logic [lbfps_pkg::IDX_W-1:0]  bi_q, bj_q;
	assign d2     = {1'b0, sqx_s3} + {1'b0, sqy_s3};
	assign better = v_s3 && ok_s3 && (d2 < best_q);

	logic out_load;
	assign out_load  = (state_q == ST_OUT) && (!res_valid || res_ready);

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			total_q   <= '0;
			i_q       <= '0;
			j_q       <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			found_q   <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (better) found_q <= 1'b1;
			if (res_valid && res_ready) res_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (store) total_q <= total_q + 1'b1;
					if (pop && bar.last) begin
						i_q     <= '0;
						found_q <= 1'b0;
						state_q <= ST_RDI;
					end
				end
				ST_RDI: begin
					state_q <= more_i ? ST_LATI : ST_OUT;
				end
				ST_LATI: begin
					j_q     <= i_q + 1'b1;
					state_q <= ST_RUNJ;
				end
				ST_RUNJ: begin
					j_q <= j_q + 1'b1;
					if (last_j) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (drained) begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_RDI;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						res_valid <= 1'b1;
						total_q   <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (pop && bar.last) best_q <= lbfps_pkg::DIST_W'(cfg.max_distance) *
			lbfps_pkg::DIST_W'(cfg.max_distance);
		else if (better) best_q <= d2;
		if (better) begin
			bi_q <= idxi_q;
			bj_q <= idxj_s3;
		end
		if (state_q == ST_LATI) begin
			xi_q   <= rdata_q[15:0];
			yi_q   <= rdata_q[31:16];
			idxi_q <= rdata_q[37:32];
		end
		dx_s2   <= dx;
		dy_s2   <= dy;
		ok_s2   <= (dy <= cfg.max_y_offset);
		idxj_s2 <= rdata_q[37:32];
		sqx_s3  <= dx_s2 * dx_s2;
		sqy_s3  <= dy_s2 * dy_s2;
		ok_s3   <= ok_s2;
		idxj_s3 <= idxj_s2;
		if (out_load) begin
			res.found            <= found_q;
			res.first_bar        <= found_q ? bi_q : '0;
			res.second_bar       <= found_q ? bj_q : '0;
			res.distance_squared <= found_q ? best_q : '0;
			res.kept_count       <= lbfps_pkg::COUNT_W'(total_q);
		end
	end

endmodule

`default_nettype wire
